FILE: rtl/sbts_pkg.sv
`timescale 1ns / 1ps

package sbts_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int STACK_COUNT_DEF = 3;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_STACK = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

endpackage

FILE: rtl/sbts_ram.sv
`timescale 1ns / 1ps

module sbts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/shared_buffer_three_stacks_top.sv
`timescale 1ns / 1ps

// Three (STACK_COUNT) stacks sharing one table of SLOT_COUNT slots. Each request word is a
// push or a pop on one stack; each produces exactly one response word with a status, the
// popped value, the full flag, the empty flag of the selected stack and the used count.
// Slots are handed out from a free FIFO that starts with every index in ascending order,
// and a popped slot goes back to the tail of that FIFO. The slot table (value plus link to
// the slot below) and the free FIFO are single-port-read synchronous RAMs with registered
// reads. The accept cycle issues the RAM reads (top slot for a pop, free index at the head
// for a push); the execute state then writes back and loads the response register. No new
// word is taken before the last one is written back. The response register decouples the
// two sides: a new word is taken while a response still waits, and its write-back simply
// holds until the response register frees up. No clearing pass is needed after reset: the
// head index itself stands in for free FIFO entries the tail has not yet reached, tracked
// by the tail pointer and a wrap flag.
module shared_buffer_three_stacks_top #(
  parameter int SLOT_COUNT  = sbts_pkg::SLOT_COUNT_DEF,
  parameter int DATA_WIDTH  = sbts_pkg::DATA_WIDTH_DEF,
  parameter int STACK_COUNT = sbts_pkg::STACK_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              mode,
  input  logic [$clog2(STACK_COUNT+1)-1:0]  stack_sel,
  input  logic [DATA_WIDTH-1:0]             push_value,
  // response channel
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [1:0]                        status,
  output logic [DATA_WIDTH-1:0]             pop_value,
  output logic                              table_full,
  output logic                              selected_empty,
  output logic [$clog2(SLOT_COUNT+1)-1:0]   used_count
);

  import sbts_pkg::*;

  // slot index, top (index or empty sentinel), stack select widths
  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int TW  = $clog2(SLOT_COUNT + 1);
  localparam int SW  = $clog2(STACK_COUNT + 1);
  localparam int SIW = $clog2(STACK_COUNT);
  localparam int EW  = DATA_WIDTH + TW;

  localparam logic [TW-1:0] NO_SLOT  = TW'(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  fsm_t state, state_next;

  // per-stack top pointers, sentinel NO_SLOT when empty
  logic [TW-1:0] tops [STACK_COUNT];

  // free FIFO pointers and the count of used slots
  logic [IW-1:0] head, tail;
  logic          tail_wrap;
  logic [TW-1:0] slots_used;

  // word captured at accept
  logic                  op_mode;
  logic [SW-1:0]         op_sel;
  logic [DATA_WIDTH-1:0] op_value;
  logic [TW-1:0]         op_top;

  logic          accept, load;
  logic          in_sel_ok;
  logic [SIW-1:0] in_sidx, op_sidx;
  logic          op_sel_ok;

  // ram ports
  logic          slot_wr_en;
  logic [IW-1:0] slot_wr_addr;
  logic [EW-1:0] slot_wr_data;
  logic [EW-1:0] slot_rd_data;
  logic          fifo_wr_en;
  logic [IW-1:0] fifo_rd_data;

  // execute-stage results
  logic                  top_empty, is_full, fifo_written;
  logic                  push_ok, pop_ok;
  logic [IW-1:0]         free_idx;
  logic [TW-1:0]         link;
  status_t               res_status;
  logic                  res_sel_empty;
  logic [TW-1:0]         used_next;
  logic [IW-1:0]         head_next, tail_next;

  // handshake and sequencing
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load       = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // write-back waits for a free response register
        if (!rsp_valid || rsp_ready) begin
          load       = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stack select decode at accept and in execute
  assign in_sel_ok = stack_sel < SW'(STACK_COUNT);
  assign in_sidx   = in_sel_ok ? stack_sel[SIW-1:0] : '0;
  assign op_sel_ok = op_sel < SW'(STACK_COUNT);
  assign op_sidx   = op_sel_ok ? op_sel[SIW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode;
      op_sel   <= stack_sel;
      op_value <= push_value;
      op_top   <= tops[in_sidx];
    end
  end

  // slot table: {link to slot below, value}
  sbts_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (accept),
    .rd_addr (tops[in_sidx][IW-1:0]),
    .rd_data (slot_rd_data)
  );

  // free index FIFO storage
  sbts_ram #(
    .WIDTH (IW),
    .DEPTH (SLOT_COUNT)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (tail),
    .wr_data (op_top[IW-1:0]),
    .rd_en   (accept),
    .rd_addr (head),
    .rd_data (fifo_rd_data)
  );

  // execute: decide, write back, form the response
  always_comb begin
    top_empty = op_top == NO_SLOT;
    is_full   = slots_used == TW'(SLOT_COUNT);
    // an entry the tail never reached still holds its own index
    fifo_written = tail_wrap || (head < tail);
    free_idx     = fifo_written ? fifo_rd_data : head;
    link         = slot_rd_data[EW-1:DATA_WIDTH];

    push_ok = op_sel_ok && (op_mode == MODE_PUSH) && !is_full;
    pop_ok  = op_sel_ok && (op_mode == MODE_POP) && !top_empty;

    priority if (!op_sel_ok) begin
      res_status    = ST_BAD_STACK;
      res_sel_empty = 1'b1;
    end else if (op_mode == MODE_PUSH) begin
      res_status    = is_full ? ST_FULL : ST_OK;
      res_sel_empty = is_full ? top_empty : 1'b0;
    end else begin
      res_status    = top_empty ? ST_EMPTY : ST_OK;
      res_sel_empty = top_empty ? 1'b1 : (link >= NO_SLOT);
    end

    used_next = slots_used;
    if (push_ok) begin
      used_next = slots_used + TW'(1);
    end else if (pop_ok && slots_used != '0) begin
      used_next = slots_used - TW'(1);
    end

    head_next = (head == LAST_IDX) ? '0 : head + IW'(1);
    tail_next = (tail == LAST_IDX) ? '0 : tail + IW'(1);

    slot_wr_en   = load && push_ok;
    slot_wr_addr = free_idx;
    slot_wr_data = {op_top, op_value};
    fifo_wr_en   = load && pop_ok;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        tops[i] <= NO_SLOT;
      end
      head       <= '0;
      tail       <= '0;
      tail_wrap  <= 1'b0;
      slots_used <= '0;
    end else if (load) begin
      slots_used <= used_next;
      if (push_ok) begin
        tops[op_sidx] <= TW'(free_idx);
        head          <= head_next;
      end
      if (pop_ok) begin
        // a link past the sentinel counts as empty
        tops[op_sidx] <= (link > NO_SLOT) ? NO_SLOT : link;
        tail          <= tail_next;
        if (tail == LAST_IDX) begin
          tail_wrap <= 1'b1;
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= load || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= res_status;
      pop_value      <= pop_ok ? slot_rd_data[DATA_WIDTH-1:0] : '0;
      table_full     <= used_next == TW'(SLOT_COUNT);
      selected_empty <= res_sel_empty;
      used_count     <= used_next;
    end
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= TW'(SLOT_COUNT))
    else $error("used count beyond table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == FSM_EXEC)
    else $error("accepted word did not enter execute");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (load && push_ok) |=> slots_used == $past(slots_used) + TW'(1))
    else $error("push did not add one slot");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> table_full == (used_count == TW'(SLOT_COUNT)))
    else $error("full flag disagrees with used count");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (head == tail) |-> (slots_used == '0 || slots_used == TW'(SLOT_COUNT)))
    else $error("free pointers disagree with used count");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import sbts_pkg::*;

  localparam int NUM_SLOTS  = SLOT_COUNT_DEF;
  localparam int NUM_STACKS = STACK_COUNT_DEF;
  localparam int SEL_W      = $clog2(STACK_COUNT_DEF + 1);
  localparam int USED_W     = $clog2(SLOT_COUNT_DEF + 1);
  // top pointer value meaning "stack holds nothing"
  localparam logic [USED_W-1:0] EMPTY_TOP = USED_W'(NUM_SLOTS);
  // first stack number past the end, rejected by the block
  localparam logic [SEL_W-1:0] BAD_SEL = SEL_W'(NUM_STACKS);
  // room for responses still in flight
  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    status_t            st;
    logic [31:0]        popped;
    logic               full;
    logic               sel_empty;
    logic [USED_W-1:0]  used;
  } stack_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all driven from time zero
  logic              req_valid  = 1'b0;
  logic              req_ready;
  logic              mode       = MODE_PUSH;
  logic [SEL_W-1:0]  stack_sel  = '0;
  logic [31:0]       push_value = '0;

  // response side
  logic              rsp_valid;
  logic              rsp_ready  = 1'b0;
  logic [1:0]        status;
  logic [31:0]       pop_value;
  logic              table_full;
  logic              selected_empty;
  logic [USED_W-1:0] used_count;

  // idle rates in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // remaining cycles of a forced receiver hold-off
  int hold_left      = 0;
  int err_count      = 0;

  // expected responses, oldest first
  stack_result_t expected_buf[EXP_DEPTH];
  int            exp_wr = 0;
  int            exp_rd = 0;

  // shadow copy of the block state
  logic [31:0]       shadow_val [NUM_SLOTS];
  logic [USED_W-1:0] shadow_link[NUM_SLOTS];
  logic [USED_W-1:0] shadow_top [NUM_STACKS];
  logic [3:0]        free_idx   [NUM_SLOTS];
  logic [3:0]        free_rd;
  logic [3:0]        free_wr;
  logic [USED_W-1:0] shadow_used;

  shared_buffer_three_stacks_top u_top (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .mode           (mode),
    .stack_sel      (stack_sel),
    .push_value     (push_value),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .pop_value      (pop_value),
    .table_full     (table_full),
    .selected_empty (selected_empty),
    .used_count     (used_count)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow model of the shared slot table
  // ---------------------------------------------------------------------------

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_val[i]  = '0;
      shadow_link[i] = '0;
      free_idx[i]    = 4'(i);
    end
    for (int s = 0; s < NUM_STACKS; s++) shadow_top[s] = EMPTY_TOP;
    free_rd     = '0;
    free_wr     = '0;
    shadow_used = '0;
  endfunction

  // apply one push or pop to the shadow state and return the response it gives
  function automatic stack_result_t apply_stack_op(logic m, logic [SEL_W-1:0] sel,
                                                   logic [31:0] val);
    stack_result_t r;
    logic [3:0]    slot;
    r.st        = ST_OK;
    r.popped    = '0;
    r.sel_empty = 1'b1;
    if (sel >= BAD_SEL) begin
      // rejected before anything else, state untouched
      r.st = ST_BAD_STACK;
    end else if (m == MODE_PUSH) begin
      if (shadow_used >= USED_W'(NUM_SLOTS)) begin
        r.st = ST_FULL;
      end else begin
        // oldest free index becomes the new top, linked to the old one
        slot              = free_idx[free_rd];
        free_rd           = free_rd + 4'd1;
        shadow_val[slot]  = val;
        shadow_link[slot] = shadow_top[sel];
        shadow_top[sel]   = USED_W'(slot);
        shadow_used       = shadow_used + 1'b1;
      end
      r.sel_empty = (shadow_top[sel] >= EMPTY_TOP);
    end else begin
      if (shadow_top[sel] >= EMPTY_TOP) begin
        r.st = ST_EMPTY;
      end else begin
        // take the top, step back along its link, recycle the slot
        slot              = shadow_top[sel][3:0];
        r.popped          = shadow_val[slot];
        shadow_top[sel]   = shadow_link[slot];
        free_idx[free_wr] = slot;
        free_wr           = free_wr + 4'd1;
        if (shadow_used > 0) shadow_used = shadow_used - 1'b1;
      end
      r.sel_empty = (shadow_top[sel] >= EMPTY_TOP);
    end
    r.full = (shadow_used >= USED_W'(NUM_SLOTS));
    r.used = shadow_used;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // called right after a rising edge; returns right after the edge that took the word
  task automatic send_word(input logic m, input logic [SEL_W-1:0] sel,
                           input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= m;
    stack_sel  <= sel;
    push_value <= val;
    // inputs only move at rising edges, so the falling edge shows a settled ready
    do @(negedge clk); while (!req_ready);
    expected_buf[exp_wr % EXP_DEPTH] = apply_stack_op(m, sel, val);
    exp_wr++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // response side: ready generation and checking
  // ---------------------------------------------------------------------------

  // a forced hold-off counts down here, otherwise random stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("tb: mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_response();
    stack_result_t want;
    if (exp_rd == exp_wr) begin
      report_mismatch("unexpected response, status", 32'(status), 32'hffff_ffff);
    end else begin
      want = expected_buf[exp_rd % EXP_DEPTH];
      exp_rd++;
      if (status != want.st)
        report_mismatch("status", 32'(status), 32'(want.st));
      if (pop_value != want.popped)       report_mismatch("pop_value", pop_value, want.popped);
      if (table_full != want.full)
        report_mismatch("table_full", 32'(table_full), 32'(want.full));
      if (selected_empty != want.sel_empty)
        report_mismatch("selected_empty", 32'(selected_empty), 32'(want.sel_empty));
      if (used_count != want.used)
        report_mismatch("used_count", 32'(used_count), 32'(want.used));
    end
  endtask

  // a word moves at the next rising edge when both are high at the falling edge
  always @(negedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_response();
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // data words with the all-zero, all-one and checkerboard patterns mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'haaaa_aaaa;
      3:       return 32'h5555_5555;
      default: return $urandom;
    endcase
  endfunction

  // mostly valid stacks with a trickle of rejected numbers as noise
  function automatic logic [SEL_W-1:0] pick_stack();
    if ($urandom_range(19) == 0) return BAD_SEL;
    return SEL_W'($urandom_range(NUM_STACKS - 1));
  endfunction

  task automatic wait_drained();
    while (exp_rd != exp_wr) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edge cases: empty pops, rejected stack, fill to full, push on full, pops
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int s = 0; s < NUM_STACKS; s++) send_word(MODE_POP, SEL_W'(s), 32'hdead_beef);
    send_word(MODE_PUSH, BAD_SEL, 32'h1234_5678);
    send_word(MODE_POP, BAD_SEL, 32'h0);
    // fill every slot, spread over the stacks, with the extreme patterns
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i % 4)
        0:       send_word(MODE_PUSH, SEL_W'(i % NUM_STACKS), 32'h0000_0000);
        1:       send_word(MODE_PUSH, SEL_W'(i % NUM_STACKS), 32'hffff_ffff);
        2:       send_word(MODE_PUSH, SEL_W'(i % NUM_STACKS), 32'haaaa_aaaa);
        default: send_word(MODE_PUSH, SEL_W'(i % NUM_STACKS), 32'h5555_5555);
      endcase
    end
    send_word(MODE_PUSH, SEL_W'(0), 32'hcafe_f00d);
    for (int s = 0; s < NUM_STACKS; s++) send_word(MODE_POP, SEL_W'(s), 32'h0);
  endtask

  // random pushes and pops; the push bias swings so the table fills and drains
  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    int push_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      push_pct = ((i / 40) % 2 == 0) ? 75 : 25;
      if ($urandom_range(99) < push_pct) send_word(MODE_PUSH, pick_stack(), pick_value());
      else                               send_word(MODE_POP, pick_stack(), pick_value());
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left <= 200;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 60) send_word(MODE_PUSH, pick_stack(), pick_value());
      else                         send_word(MODE_POP, pick_stack(), pick_value());
    end
  endtask

  // sender stops until every response is back, then resumes
  task automatic test_sender_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    for (int i = 0; i < 10; i++) send_word(MODE_PUSH, pick_stack(), pick_value());
    req_valid <= 1'b0;
    wait_drained();
    for (int i = 0; i < 10; i++) send_word(MODE_POP, pick_stack(), pick_value());
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(170, 0, 0);
    test_random(170, 51, 0);
    test_backpressure();
    test_random(170, 0, 51);
    test_sender_pause();
    test_random(170, 11, 11);

    // let the tail of the traffic come back, then a few spare cycles
    req_valid <= 1'b0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
